// ----- rtl/core/i2a_pkg.sv -----
// shared types, constants and helpers of the integer to ascii field formatter
package i2a_pkg;

    // field limits
    localparam int MAX_WIDTH  = 32;
    localparam int VALUE_W    = 32;
    localparam int WIDTH_W    = 6;
    localparam int NDIG       = 10;
    localparam int NDIG_W     = 4;
    localparam int CHAR_W     = 8;
    localparam int BIT_CNT_W  = 5;

    // radix codes
    localparam logic [1:0] RADIX_DEC    = 2'd0;
    localparam logic [1:0] RADIX_HEX_LO = 2'd1;
    localparam logic [1:0] RADIX_HEX_UP = 2'd2;

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [3:0] DEC_BASE = 4'd10;

    typedef logic [NDIG-1:0][3:0] digits_t;

    // conversion result flags towards the character sequencer
    typedef struct packed {
        logic              done;
        logic [NDIG_W-1:0] ndig;
    } conv_status_t;

    // command that starts a character run
    typedef struct packed {
        logic               start;
        logic               neg;
        logic               pad_zero;
        logic               upper;
        logic [WIDTH_W-1:0] field_width;
        logic [NDIG_W-1:0]  ndig;
    } emit_cmd_t;

    // one digit nibble to its ascii character
    function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        begin
            base = upper ? CH_UP_A : CH_LO_A;
            if (nib < DEC_BASE)
                digit_char = CH_ZERO + {4'd0, nib};
            else
                digit_char = base + {4'd0, nib - DEC_BASE};
        end
    endfunction

endpackage

// ----- rtl/core/i2a_in_if.sv -----
// input channel: one integer with its format controls per word
interface i2a_in_if;
    logic                              valid;
    logic                              ready;
    logic [i2a_pkg::VALUE_W-1:0]       value;
    logic                              is_signed;
    logic [1:0]                        radix_mode;
    logic                              pad_zero;
    logic [i2a_pkg::WIDTH_W-1:0]       width;

    modport source (output valid, value, is_signed, radix_mode, pad_zero, width,
                    input ready);
    modport sink   (input valid, value, is_signed, radix_mode, pad_zero, width,
                    output ready);
endinterface

// ----- rtl/core/i2a_out_if.sv -----
// output channel: one ascii character per word
interface i2a_out_if;
    logic                        valid;
    logic                        ready;
    logic [i2a_pkg::CHAR_W-1:0]  out_char;
    logic                        last;

    modport source (output valid, out_char, last, input ready);
    modport sink   (input valid, out_char, last, output ready);
endinterface

// ----- rtl/core/i2a_dabble.sv -----
// bit-serial binary to bcd / hex nibble converter, one operand bit per cycle
module i2a_dabble (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          decimal,
    input  logic [i2a_pkg::VALUE_W-1:0]   value,
    output i2a_pkg::digits_t              digits,
    output i2a_pkg::conv_status_t         status
);
    import i2a_pkg::*;

    logic [VALUE_W-1:0]   shf_reg, shf_next;
    logic [NDIG*4-1:0]    bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 dec_reg, dec_next;
    digits_t              corr;
    logic [NDIG_W-1:0]    nd;

    // add-three correction on every bcd digit
    always_comb
    begin
        corr = bcd_reg;
        if (dec_reg)
        begin
            for (int i = 0; i < NDIG; i++)
            begin
                if (corr[i] >= 4'd5)
                    corr[i] = corr[i] + 4'd3;
            end
        end
    end

    // shift sequencing
    always_comb
    begin
        shf_next  = shf_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        dec_next  = dec_reg;
        done_next = 1'b0;
        if (start)
        begin
            shf_next  = value;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            dec_next  = decimal;
        end
        else if (busy_reg)
        begin
            bcd_next = {corr[NDIG-1][2:0], corr[NDIG-2:0], shf_reg[VALUE_W-1]};
            shf_next = {shf_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == {BIT_CNT_W{1'b1}})
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        shf_reg <= shf_next;
        bcd_reg <= bcd_next;
        dec_reg <= dec_next;
    end

    // significant digit count, at least one
    always_comb
    begin
        nd = NDIG_W'(1);
        for (int i = 1; i < NDIG; i++)
        begin
            if (bcd_reg[i*4 +: 4] != 4'd0)
                nd = NDIG_W'(i + 1);
        end
    end

    assign digits      = bcd_reg;
    assign status.done = done_reg;
    assign status.ndig = nd;

endmodule

// ----- rtl/core/i2a_emit.sv -----
// character sequencer: sign, padding and digits, one character per word
module i2a_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  i2a_pkg::emit_cmd_t   cmd,
    input  i2a_pkg::digits_t     digits,
    output logic                 busy,
    i2a_out_if.source            out_ch
);
    import i2a_pkg::*;

    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;
    logic               valid_reg, valid_next;
    logic               more_reg, more_next;
    logic [WIDTH_W-1:0] pos_reg, pos_next;
    logic               padz_reg, padz_next;
    logic               upper_reg, upper_next;
    logic [NDIG_W-1:0]  ndig_reg, ndig_next;
    digits_t            dig_reg, dig_next;
    logic               accepted;
    logic               load;
    logic [3:0]         nib;
    logic [CHAR_W-1:0]  pos_char;

    assign accepted = valid_reg && out_ch.ready;
    assign load     = more_reg && (!valid_reg || accepted);

    // character at the current field position
    always_comb
    begin
        nib = 4'd0;
        for (int i = 0; i < NDIG; i++)
        begin
            if (pos_reg == WIDTH_W'(i))
                nib = dig_reg[i];
        end
        if (pos_reg < {{(WIDTH_W-NDIG_W){1'b0}}, ndig_reg})
            pos_char = digit_char(nib, upper_reg);
        else
            pos_char = padz_reg ? CH_ZERO : CH_SPACE;
    end

    // run sequencing and output register
    always_comb
    begin
        char_next  = char_reg;
        last_next  = last_reg;
        valid_next = valid_reg;
        more_next  = more_reg;
        pos_next   = pos_reg;
        padz_next  = padz_reg;
        upper_next = upper_reg;
        ndig_next  = ndig_reg;
        dig_next   = dig_reg;
        if (cmd.start)
        begin
            padz_next  = cmd.pad_zero;
            upper_next = cmd.upper;
            ndig_next  = cmd.ndig;
            dig_next   = digits;
            pos_next   = cmd.field_width - 1'b1;
            more_next  = 1'b1;
            valid_next = cmd.neg;
            char_next  = CH_MINUS;
            last_next  = 1'b0;
        end
        else if (load)
        begin
            char_next  = pos_char;
            last_next  = (pos_reg == '0);
            more_next  = (pos_reg != '0);
            pos_next   = pos_reg - 1'b1;
            valid_next = 1'b1;
        end
        else if (accepted)
        begin
            valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            more_reg  <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            more_reg  <= more_next;
            pos_reg   <= pos_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        last_reg  <= last_next;
        padz_reg  <= padz_next;
        upper_reg <= upper_next;
        ndig_reg  <= ndig_next;
        dig_reg   <= dig_next;
    end

    assign busy            = valid_reg || more_reg;
    assign out_ch.valid    = valid_reg;
    assign out_ch.out_char = char_reg;
    assign out_ch.last     = last_reg;

endmodule

// ----- rtl/core/int_to_ascii_field_formatter.sv -----
// top level of the integer to ascii field formatter
//
// in_ch takes one word: a 32-bit value, a signed flag, a radix code (decimal,
// lowercase hex, uppercase hex; code 3 acts as uppercase hex), a zero-pad flag
// and a field width (0 selects the natural digit count, widths above 32 are
// clamped to 32). out_ch returns one ascii character per word: a minus sign
// for negative signed decimals, padding, then digits, the final one with last.
// A field narrower than the digit count keeps the lowest digits.
// The value is shifted through the binary to bcd converter one bit per cycle;
// when the conversion is done the run starts, a sign (if any) being loaded
// straight into the output register. Characters then leave one per cycle while
// out_ch.ready is high. One word is processed at a time: in_ch.ready is high
// only while idle, so a new word is taken once the previous run has ended.
// A stalled receiver simply holds the output register; the run resumes when
// out_ch.ready returns. Reset empties the converter and the output register and
// returns the block to idle with in_ch.ready high.
module int_to_ascii_field_formatter (
    input  logic       clk,
    input  logic       rst_n,
    i2a_in_if.sink     in_ch,
    i2a_out_if.source  out_ch
);
    import i2a_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic               neg_reg, neg_next;
    logic               padz_reg, padz_next;
    logic               upper_reg, upper_next;
    logic [WIDTH_W-1:0] wsat_reg, wsat_next;
    logic               accept;
    logic               decimal;
    logic               neg_in;
    logic [VALUE_W-1:0] mag;
    digits_t            digits;
    conv_status_t       conv_st;
    emit_cmd_t          cmd;
    logic               emit_busy;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    // magnitude of the operand
    assign decimal = (in_ch.radix_mode == RADIX_DEC);
    assign neg_in  = decimal && in_ch.is_signed && in_ch.value[VALUE_W-1];
    assign mag     = neg_in ? (~in_ch.value + 1'b1) : in_ch.value;

    i2a_dabble u_dabble (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .decimal (decimal),
        .value   (mag),
        .digits  (digits),
        .status  (conv_st)
    );

    // run command once the digits are ready
    always_comb
    begin
        cmd.start       = conv_st.done;
        cmd.neg         = neg_reg;
        cmd.pad_zero    = padz_reg;
        cmd.upper       = upper_reg;
        cmd.ndig        = conv_st.ndig;
        cmd.field_width = (wsat_reg == '0) ?
                          {{(WIDTH_W-NDIG_W){1'b0}}, conv_st.ndig} : wsat_reg;
    end

    i2a_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .digits (digits),
        .busy   (emit_busy),
        .out_ch (out_ch)
    );

    // item capture and state sequencing
    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        padz_next  = padz_reg;
        upper_next = upper_reg;
        wsat_next  = wsat_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = neg_in;
                    padz_next  = in_ch.pad_zero;
                    upper_next = (in_ch.radix_mode != RADIX_HEX_LO);
                    wsat_next  = (in_ch.width > WIDTH_W'(MAX_WIDTH)) ?
                                 WIDTH_W'(MAX_WIDTH) : in_ch.width;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_st.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!emit_busy)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // captured format controls
    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        padz_reg  <= padz_next;
        upper_reg <= upper_next;
        wsat_reg  <= wsat_next;
    end

endmodule
